### design/ticket_fifo_with_duplicate_key_reject_assert.svh
// Assertion macros shared by the ticket FIFO modules.
`ifndef TICKET_FIFO_WITH_DUPLICATE_KEY_REJECT_ASSERT_SVH
`define TICKET_FIFO_WITH_DUPLICATE_KEY_REJECT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TKF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tkfifo assertion failed");

// Next-cycle implication, checked out of reset.
`define TKF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tkfifo assertion failed");

`endif

### design/tkfifo_pkg.sv
// Shared types, constants and helpers for the ticket FIFO.
package tkfifo_pkg;

    localparam int DEPTH    = 64;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int CAP_W    = 7;
    localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int KEY_W    = 54;
    localparam int TAG_W    = 32;
    localparam int TICKET_W = 16;
    localparam int STATUS_W = 3;

    localparam logic [CAP_W-1:0]    CAP_RESET    = CAP_W'(50);
    localparam logic [TICKET_W-1:0] TICKET_RESET = TICKET_W'(1);

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_DEQUEUED  = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_DRAIN,
        S_VERDICT,
        S_DEQ_WAIT
    } state_t;

    typedef struct packed {
        logic    latch_in;
        logic    scan_init;
        logic    scan_step;
        logic    deq_read;
        logic    res_load;
        status_t res_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic mode;
        logic full;
        logic empty;
        logic scan_last;
        logic match;
    } dp_stat_t;

    function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

### design/ticket_fifo_with_duplicate_key_reject.sv
// Top level of the ticket FIFO with duplicate key rejection.
//
//  channel   handshake               word
//  --------  ----------------------  --------------------------------------------
//  request   start & !busy           mode, applicant_key, applicant_tag
//  result    done (one-cycle strobe) status, ticket, out_key, out_tag, occupancy
//  config    cfg_we                  cfg_wdata (capacity limit)
//
//  An enqueue below the limit over n > 0 held entries scans them for a duplicate key:
//  the check reads one stored key per cycle through one port. A dequeue reads the head
//  entry; a full word, an empty dequeue or an enqueue into an empty queue needs no read.
//  The next word can be accepted in the cycle in which done is high.
//  Reset is asynchronous, active low; the queue comes up empty, no clearing pass.
//  The result receiver cannot stall; the request side waits while busy is high.
module ticket_fifo_with_duplicate_key_reject (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                mode,
    input  logic [tkfifo_pkg::KEY_W-1:0]        applicant_key,
    input  logic [tkfifo_pkg::TAG_W-1:0]        applicant_tag,
    input  logic                                cfg_we,
    input  logic [tkfifo_pkg::CAP_W-1:0]        cfg_wdata,
    output logic                                done,
    output logic [tkfifo_pkg::STATUS_W-1:0]     status,
    output logic [tkfifo_pkg::TICKET_W-1:0]     ticket,
    output logic [tkfifo_pkg::KEY_W-1:0]        out_key,
    output logic [tkfifo_pkg::TAG_W-1:0]        out_tag,
    output logic [tkfifo_pkg::CNT_W-1:0]        occupancy
);

    tkfifo_pkg::ctrl_cmd_t cmd;
    tkfifo_pkg::dp_stat_t  stat;

    tkfifo_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tkfifo_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .mode          (mode),
        .applicant_key (applicant_key),
        .applicant_tag (applicant_tag),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .status        (status),
        .ticket        (ticket),
        .out_key       (out_key),
        .out_tag       (out_tag),
        .occupancy     (occupancy)
    );

endmodule

### design/tkfifo_ctrl.sv
// Sequencing state machine for the ticket FIFO.
`include "ticket_fifo_with_duplicate_key_reject_assert.svh"

module tkfifo_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  tkfifo_pkg::dp_stat_t  stat,
    output tkfifo_pkg::ctrl_cmd_t cmd,
    output logic                  busy
);

    tkfifo_pkg::state_t state_reg;
    tkfifo_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tkfifo_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tkfifo_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = tkfifo_pkg::S_EVAL;
                end
            end
            tkfifo_pkg::S_EVAL:
            begin
                if (stat.mode)
                begin
                    state_next = stat.empty ? tkfifo_pkg::S_IDLE : tkfifo_pkg::S_DEQ_WAIT;
                end
                else if (stat.full || stat.empty)
                begin
                    state_next = tkfifo_pkg::S_IDLE;
                end
                else
                begin
                    state_next = tkfifo_pkg::S_SCAN;
                end
            end
            tkfifo_pkg::S_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = tkfifo_pkg::S_DRAIN;
                end
            end
            tkfifo_pkg::S_DRAIN:
            begin
                state_next = tkfifo_pkg::S_VERDICT;
            end
            tkfifo_pkg::S_VERDICT:
            begin
                state_next = tkfifo_pkg::S_IDLE;
            end
            tkfifo_pkg::S_DEQ_WAIT:
            begin
                state_next = tkfifo_pkg::S_IDLE;
            end
            default:
            begin
                state_next = tkfifo_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.res_status = tkfifo_pkg::ST_ACCEPTED;
        busy           = 1'b1;
        unique case (state_reg)
            tkfifo_pkg::S_IDLE:
            begin
                busy         = 1'b0;
                cmd.latch_in = start;
            end
            tkfifo_pkg::S_EVAL:
            begin
                if (stat.mode)
                begin
                    if (stat.empty)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = tkfifo_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cmd.deq_read = 1'b1;
                    end
                end
                else if (stat.full)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = tkfifo_pkg::ST_FULL;
                end
                else if (stat.empty)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = tkfifo_pkg::ST_ACCEPTED;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                end
            end
            tkfifo_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            tkfifo_pkg::S_DRAIN:
            begin
                cmd = '0;
            end
            tkfifo_pkg::S_VERDICT:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_status = stat.match ? tkfifo_pkg::ST_DUPLICATE
                                            : tkfifo_pkg::ST_ACCEPTED;
            end
            tkfifo_pkg::S_DEQ_WAIT:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_status = tkfifo_pkg::ST_DEQUEUED;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // a scan only runs over a non-empty queue
    `TKF_ASSERT_SAME(a_scan_nonempty, clk, rst_n,
                     state_reg == tkfifo_pkg::S_SCAN, !stat.empty)

endmodule

### design/tkfifo_dp.sv
// Storage, pointers, key scan and result registers of the ticket FIFO.
`include "ticket_fifo_with_duplicate_key_reject_assert.svh"

module tkfifo_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tkfifo_pkg::ctrl_cmd_t               cmd,
    output tkfifo_pkg::dp_stat_t                stat,
    input  logic                                mode,
    input  logic [tkfifo_pkg::KEY_W-1:0]        applicant_key,
    input  logic [tkfifo_pkg::TAG_W-1:0]        applicant_tag,
    input  logic                                cfg_we,
    input  logic [tkfifo_pkg::CAP_W-1:0]        cfg_wdata,
    output logic                                done,
    output logic [tkfifo_pkg::STATUS_W-1:0]     status,
    output logic [tkfifo_pkg::TICKET_W-1:0]     ticket,
    output logic [tkfifo_pkg::KEY_W-1:0]        out_key,
    output logic [tkfifo_pkg::TAG_W-1:0]        out_tag,
    output logic [tkfifo_pkg::CNT_W-1:0]        occupancy
);

    logic [tkfifo_pkg::KEY_W-1:0]    key_mem    [tkfifo_pkg::DEPTH];
    logic [tkfifo_pkg::TAG_W-1:0]    tag_mem    [tkfifo_pkg::DEPTH];
    logic [tkfifo_pkg::TICKET_W-1:0] ticket_mem [tkfifo_pkg::DEPTH];

    logic [tkfifo_pkg::KEY_W-1:0]    rd_key_reg;
    logic [tkfifo_pkg::TAG_W-1:0]    rd_tag_reg;
    logic [tkfifo_pkg::TICKET_W-1:0] rd_ticket_reg;

    logic                            mode_reg;
    logic [tkfifo_pkg::KEY_W-1:0]    key_reg;
    logic [tkfifo_pkg::TAG_W-1:0]    tag_reg;

    logic [tkfifo_pkg::CAP_W-1:0]    cap_reg;
    logic [tkfifo_pkg::PTR_W-1:0]    head_reg;
    logic [tkfifo_pkg::PTR_W-1:0]    tail_reg;
    logic [tkfifo_pkg::CNT_W-1:0]    count_reg;
    logic [tkfifo_pkg::TICKET_W-1:0] next_ticket_reg;
    logic [tkfifo_pkg::PTR_W-1:0]    scan_ptr_reg;
    logic [tkfifo_pkg::CNT_W-1:0]    scan_left_reg;
    logic                            cmp_vld_reg;
    logic                            match_reg;
    logic                            match_next;
    logic                            done_reg;

    tkfifo_pkg::status_t             res_status_reg;
    logic [tkfifo_pkg::TICKET_W-1:0] res_ticket_reg;
    logic [tkfifo_pkg::KEY_W-1:0]    res_key_reg;
    logic [tkfifo_pkg::TAG_W-1:0]    res_tag_reg;
    logic [tkfifo_pkg::CNT_W-1:0]    res_occ_reg;

    logic [tkfifo_pkg::PTR_W-1:0]    rd_addr;
    logic                            rd_en;
    logic                            do_push;
    logic                            do_pop;

    assign rd_addr = cmd.deq_read ? head_reg : scan_ptr_reg;
    assign rd_en   = cmd.deq_read | cmd.scan_step;
    assign do_push = cmd.res_load && (cmd.res_status == tkfifo_pkg::ST_ACCEPTED);
    assign do_pop  = cmd.res_load && (cmd.res_status == tkfifo_pkg::ST_DEQUEUED);

    assign match_next = match_reg | (cmp_vld_reg && (rd_key_reg == key_reg));

    assign stat.mode      = mode_reg;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == tkfifo_pkg::CNT_W'(tkfifo_pkg::DEPTH))
                         || (tkfifo_pkg::CMP_W'(count_reg) >= tkfifo_pkg::CMP_W'(cap_reg));
    assign stat.scan_last = (scan_left_reg == tkfifo_pkg::CNT_W'(1));
    assign stat.match     = match_reg;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            key_mem[tail_reg]    <= key_reg;
            tag_mem[tail_reg]    <= tag_reg;
            ticket_mem[tail_reg] <= next_ticket_reg;
        end
        if (rd_en)
        begin
            rd_key_reg    <= key_mem[rd_addr];
            rd_tag_reg    <= tag_mem[rd_addr];
            rd_ticket_reg <= ticket_mem[rd_addr];
        end
    end

    // request word and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            mode_reg <= mode;
            key_reg  <= applicant_key;
            tag_reg  <= applicant_tag;
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            if (do_push)
            begin
                res_ticket_reg <= next_ticket_reg;
                res_key_reg    <= '0;
                res_tag_reg    <= '0;
                res_occ_reg    <= count_reg + tkfifo_pkg::CNT_W'(1);
            end
            else if (do_pop)
            begin
                res_ticket_reg <= rd_ticket_reg;
                res_key_reg    <= rd_key_reg;
                res_tag_reg    <= rd_tag_reg;
                res_occ_reg    <= count_reg - tkfifo_pkg::CNT_W'(1);
            end
            else
            begin
                res_ticket_reg <= '0;
                res_key_reg    <= '0;
                res_tag_reg    <= '0;
                res_occ_reg    <= count_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg         <= tkfifo_pkg::CAP_RESET;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            next_ticket_reg <= tkfifo_pkg::TICKET_RESET;
            scan_ptr_reg    <= '0;
            scan_left_reg   <= '0;
            cmp_vld_reg     <= 1'b0;
            match_reg       <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            done_reg    <= cmd.res_load;
            cmp_vld_reg <= cmd.scan_step;
            if (cmd.scan_init)
            begin
                scan_ptr_reg  <= head_reg;
                scan_left_reg <= count_reg;
                match_reg     <= 1'b0;
            end
            else
            begin
                match_reg <= match_next;
                if (cmd.scan_step)
                begin
                    scan_ptr_reg  <= tkfifo_pkg::ptr_adv(scan_ptr_reg);
                    scan_left_reg <= scan_left_reg - tkfifo_pkg::CNT_W'(1);
                end
            end
            if (do_push)
            begin
                tail_reg        <= tkfifo_pkg::ptr_adv(tail_reg);
                count_reg       <= count_reg + tkfifo_pkg::CNT_W'(1);
                next_ticket_reg <= next_ticket_reg + tkfifo_pkg::TICKET_W'(1);
            end
            if (do_pop)
            begin
                head_reg  <= tkfifo_pkg::ptr_adv(head_reg);
                count_reg <= count_reg - tkfifo_pkg::CNT_W'(1);
            end
        end
    end

    assign done      = done_reg;
    assign status    = res_status_reg;
    assign ticket    = res_ticket_reg;
    assign out_key   = res_key_reg;
    assign out_tag   = res_tag_reg;
    assign occupancy = res_occ_reg;

    `TKF_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1,
                     count_reg <= tkfifo_pkg::CNT_W'(tkfifo_pkg::DEPTH))
    `TKF_ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg)
    `TKF_ASSERT_SAME(a_pop_nonempty, clk, rst_n, do_pop, count_reg != '0)
    `TKF_ASSERT_SAME(a_push_occ, clk, rst_n,
                     done_reg && (res_status_reg == tkfifo_pkg::ST_ACCEPTED),
                     res_occ_reg == count_reg)

endmodule

### verif/tkfifo_result_checker.sv
// Result checker for the ticket FIFO: predicts every result word and compares it.
module tkfifo_result_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              mode,
    input  logic [tkfifo_pkg::KEY_W-1:0]      applicant_key,
    input  logic [tkfifo_pkg::TAG_W-1:0]      applicant_tag,
    input  logic                              cfg_we,
    input  logic [tkfifo_pkg::CAP_W-1:0]      cfg_wdata,
    input  logic                              done,
    input  logic [tkfifo_pkg::STATUS_W-1:0]   status,
    input  logic [tkfifo_pkg::TICKET_W-1:0]   ticket,
    input  logic [tkfifo_pkg::KEY_W-1:0]      out_key,
    input  logic [tkfifo_pkg::TAG_W-1:0]      out_tag,
    input  logic [tkfifo_pkg::CNT_W-1:0]      occupancy,
    output int                                error_count,
    output int                                outstanding,
    output int                                seen_accepted,
    output int                                seen_full,
    output int                                seen_duplicate,
    output int                                seen_dequeued,
    output int                                seen_empty
);
    import tkfifo_pkg::*;

    localparam logic OP_ENQ = 1'b0;

    typedef struct packed {
        status_t               status;
        logic [TICKET_W-1:0]   ticket;
        logic [KEY_W-1:0]      key;
        logic [TAG_W-1:0]      tag;
        logic [CNT_W-1:0]      occ;
    } outcome_t;

    logic [KEY_W-1:0]    key_mem    [DEPTH];
    logic [TAG_W-1:0]    tag_mem    [DEPTH];
    logic [TICKET_W-1:0] ticket_mem [DEPTH];
    int                  head_idx;
    int                  tail_idx;
    int                  held;
    logic [TICKET_W-1:0] next_ticket;
    logic [CAP_W-1:0]    cap_reg;
    outcome_t            awaited [$];
    outcome_t            got;
    outcome_t            want;
    int                  word_idx;

    function automatic int bump(input int p);
        return (p + 1 >= DEPTH) ? 0 : p + 1;
    endfunction

    function automatic outcome_t predict_ticket_op(input logic op,
                                                   input logic [KEY_W-1:0] k,
                                                   input logic [TAG_W-1:0] t);
        outcome_t r;
        int       limit;
        int       p;
        int       n;
        bit       dup;
        r = '0;
        limit = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
        if (op == OP_ENQ)
        begin
            dup = 1'b0;
            p = head_idx;
            for (n = 0; n < held; n++)
            begin
                if (key_mem[p] == k)
                    dup = 1'b1;
                p = bump(p);
            end
            if (held >= limit)
                r.status = ST_FULL;
            else if (dup)
                r.status = ST_DUPLICATE;
            else
            begin
                key_mem[tail_idx]    = k;
                tag_mem[tail_idx]    = t;
                ticket_mem[tail_idx] = next_ticket;
                r.ticket    = next_ticket;
                next_ticket = next_ticket + TICKET_W'(1);
                tail_idx    = bump(tail_idx);
                held++;
                r.status = ST_ACCEPTED;
            end
        end
        else
        begin
            if (held == 0)
                r.status = ST_EMPTY;
            else
            begin
                r.key    = key_mem[head_idx];
                r.tag    = tag_mem[head_idx];
                r.ticket = ticket_mem[head_idx];
                head_idx = bump(head_idx);
                held--;
                r.status = ST_DEQUEUED;
            end
        end
        r.occ = CNT_W'(held);
        return r;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR: %s", msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_idx       = 0;
            tail_idx       = 0;
            held           = 0;
            next_ticket    = TICKET_RESET;
            cap_reg        = CAP_RESET;
            awaited.delete();
            error_count    = 0;
            outstanding    = 0;
            seen_accepted  = 0;
            seen_full      = 0;
            seen_duplicate = 0;
            seen_dequeued  = 0;
            seen_empty     = 0;
            word_idx       = 0;
        end
        else
        begin
            if (done)
            begin
                got.status = status_t'(status);
                got.ticket = ticket;
                got.key    = out_key;
                got.tag    = out_tag;
                got.occ    = occupancy;
                if (awaited.size() == 0)
                    flag_error($sformatf("result word with none expected: status %0d ticket %0d",
                                         got.status, got.ticket));
                else
                begin
                    want = awaited.pop_front();
                    if (got.status !== want.status || got.ticket !== want.ticket ||
                        got.key !== want.key || got.tag !== want.tag || got.occ !== want.occ)
                        flag_error($sformatf({"word %0d: expected status %0d ticket %0d key %h",
                            " tag %h occupancy %0d, got status %0d ticket %0d key %h tag %h",
                            " occupancy %0d"}, word_idx, want.status, want.ticket, want.key,
                            want.tag, want.occ, got.status, got.ticket, got.key, got.tag,
                            got.occ));
                end
                word_idx++;
            end
            if (start && !busy)
            begin
                want = predict_ticket_op(mode, applicant_key, applicant_tag);
                case (want.status)
                    ST_ACCEPTED:  seen_accepted++;
                    ST_FULL:      seen_full++;
                    ST_DUPLICATE: seen_duplicate++;
                    ST_DEQUEUED:  seen_dequeued++;
                    default:      seen_empty++;
                endcase
                awaited.push_back(want);
            end
            if (cfg_we)
                cap_reg = cfg_wdata;
            outstanding = awaited.size();
        end
    end

endmodule

### verif/tb_ticket_fifo_with_duplicate_key_reject.sv
// Testbench top for the ticket FIFO: drives request and capacity words, gives the verdict.
module tb_ticket_fifo_with_duplicate_key_reject;
    import tkfifo_pkg::*;

    localparam logic OP_ENQ      = 1'b0;
    localparam logic OP_DEQ      = 1'b1;
    localparam int   CYCLE_LIMIT = 4000000;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                start         = 1'b0;
    logic                mode          = 1'b0;
    logic [KEY_W-1:0]    applicant_key = '0;
    logic [TAG_W-1:0]    applicant_tag = '0;
    logic                cfg_we        = 1'b0;
    logic [CAP_W-1:0]    cfg_wdata     = '0;
    logic                busy;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [TICKET_W-1:0] ticket;
    logic [KEY_W-1:0]    out_key;
    logic [TAG_W-1:0]    out_tag;
    logic [CNT_W-1:0]    occupancy;

    int                  error_count;
    int                  outstanding;
    int                  seen_accepted;
    int                  seen_full;
    int                  seen_duplicate;
    int                  seen_dequeued;
    int                  seen_empty;

    logic [KEY_W-1:0]    recent_keys [16];
    int                  recent_wr = 0;
    int                  words_sent = 0;
    int                  cycles = 0;
    bit                  idle_on = 1'b1;

    ticket_fifo_with_duplicate_key_reject uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .applicant_key (applicant_key),
        .applicant_tag (applicant_tag),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .status        (status),
        .ticket        (ticket),
        .out_key       (out_key),
        .out_tag       (out_tag),
        .occupancy     (occupancy)
    );

    tkfifo_result_checker watch (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .applicant_key  (applicant_key),
        .applicant_tag  (applicant_tag),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .done           (done),
        .status         (status),
        .ticket         (ticket),
        .out_key        (out_key),
        .out_tag        (out_tag),
        .occupancy      (occupancy),
        .error_count    (error_count),
        .outstanding    (outstanding),
        .seen_accepted  (seen_accepted),
        .seen_full      (seen_full),
        .seen_duplicate (seen_duplicate),
        .seen_dequeued  (seen_dequeued),
        .seen_empty     (seen_empty)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_word(input logic op, input logic [KEY_W-1:0] k,
                             input logic [TAG_W-1:0] t);
        start         <= 1'b1;
        mode          <= op;
        applicant_key <= k;
        applicant_tag <= t;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        words_sent++;
        if (op == OP_ENQ)
        begin
            recent_keys[recent_wr] = k;
            recent_wr = (recent_wr + 1) % 16;
        end
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
    endtask

    // quiet the request side until every expected word has come back
    task automatic settle();
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key(input int reuse_pct);
        logic [KEY_W-1:0] k;
        int               r;
        r = int'($urandom_range(0, 99));
        if (r < reuse_pct)
            k = recent_keys[$urandom_range(0, 15)];
        else if (r < reuse_pct + 4)
            k = '0;
        else if (r < reuse_pct + 8)
            k = '1;
        else
            k = KEY_W'({$urandom, $urandom});
        return k;
    endfunction

    task automatic random_run(input int n, input int enq_pct, input int reuse_pct);
        int   i;
        logic op;
        for (i = 0; i < n; i++)
        begin
            op = (int'($urandom_range(0, 99)) < enq_pct) ? OP_ENQ : OP_DEQ;
            send_word(op, pick_key(reuse_pct), $urandom);
        end
    endtask

    initial
    begin
        foreach (recent_keys[i])
            recent_keys[i] = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset capacity: empty, extremes, duplicate, alternating bits
        send_word(OP_DEQ, '1, '1);
        send_word(OP_ENQ, '0, '0);
        send_word(OP_ENQ, '1, '1);
        send_word(OP_ENQ, '0, 32'h5555_5555);
        send_word(OP_ENQ, {27{2'b10}}, 32'hAAAA_AAAA);
        send_word(OP_ENQ, {27{2'b01}}, 32'h5555_5555);
        repeat (5) send_word(OP_DEQ, '0, '0);

        // full beats duplicate
        set_capacity(CAP_W'(1));
        send_word(OP_ENQ, KEY_W'(54'h12345), 32'h1);
        send_word(OP_ENQ, KEY_W'(54'h12345), 32'h2);
        send_word(OP_ENQ, KEY_W'(54'h54321), 32'h3);
        send_word(OP_DEQ, '0, '0);
        send_word(OP_DEQ, '0, '0);

        set_capacity(CAP_W'(0));
        send_word(OP_ENQ, KEY_W'(54'h777), 32'h4);
        send_word(OP_DEQ, '0, '0);

        // limit saturates at depth
        set_capacity('1);
        random_run(200, 75, 20);

        // limit below the held count
        set_capacity(CAP_W'(3));
        random_run(150, 35, 20);

        set_capacity(CAP_W'(DEPTH));
        random_run(200, 60, 20);

        set_capacity(CAP_W'(8));
        random_run(150, 50, 60);

        set_capacity(CAP_W'(DEPTH + 1));
        random_run(100, 60, 20);
        idle_on = 1'b0;
        random_run(150, 55, 20);

        settle();
        repeat (72) @(negedge clk);

        $display("Sent %0d request words over capacities 0, 1, 3, 8, 50, 64, 65, 127",
                 words_sent);
        $display("Results: %0d accepted, %0d full, %0d duplicate, %0d dequeued, %0d empty",
                 seen_accepted, seen_full, seen_duplicate, seen_dequeued, seen_empty);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/tkfifo_pkg.sv
design/tkfifo_ctrl.sv
design/tkfifo_dp.sv
design/ticket_fifo_with_duplicate_key_reject.sv
verif/tkfifo_result_checker.sv
verif/tb_ticket_fifo_with_duplicate_key_reject.sv
